>>> design/rlim_pkg.sv
// Shared types and constants for the multi-scope login rate limiter.
// Used by rlim_cfg, rlim_ctrl and the top level; depends on nothing.
package rlim_pkg;

	localparam int KEY_BITS  = 32;
	localparam int TIME_BITS = 32;
	localparam int LIM_BITS  = 5;
	localparam int CAP_BITS  = 7;
	localparam int IDX_BITS  = 3;
	localparam int DATA_BITS = 32;
	localparam int NUM_SCOPES = 4;

	localparam logic [IDX_BITS-1:0] REG_LIMIT_GLOBAL   = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_LIMIT_ADDRESS  = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_LIMIT_IDENTITY = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_LIMIT_PAIR     = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_CAPACITY       = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_WINDOW         = 3'd5;

	localparam logic [1:0] BSCOPE_GLOBAL   = 2'd0;
	localparam logic [1:0] BSCOPE_ADDRESS  = 2'd1;
	localparam logic [1:0] BSCOPE_IDENTITY = 2'd2;
	localparam logic [1:0] BSCOPE_PAIR     = 2'd3;

	localparam logic [2:0] LSCOPE_NONE = 3'd0;

	typedef struct packed {
		logic [NUM_SCOPES-1:0][LIM_BITS-1:0] limit;
		logic [CAP_BITS-1:0]                 capacity;
		logic [TIME_BITS-1:0]                window;
	} cfg_t;

endpackage

>>> design/rlim_cfg.sv
// Configuration registers of the rate limiter and their effective values.
// Depends on rlim_pkg.
module rlim_cfg #(
	parameter int BUCKETS      = 64,
	parameter int MAX_ATTEMPTS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rlim_pkg::IDX_BITS-1:0]      cfg_index,
	input  logic [rlim_pkg::DATA_BITS-1:0]     cfg_data,
	output rlim_pkg::cfg_t                     cfg_eff
);
	localparam int LB = rlim_pkg::LIM_BITS;
	localparam int CB = rlim_pkg::CAP_BITS;

	logic [rlim_pkg::NUM_SCOPES-1:0][LB-1:0] lim_q;
	logic [CB-1:0]                           cap_q;
	logic [rlim_pkg::TIME_BITS-1:0]          win_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q[0] <= LB'(16);
			lim_q[1] <= LB'(8);
			lim_q[2] <= LB'(8);
			lim_q[3] <= LB'(4);
			cap_q    <= CB'(64);
			win_q    <= rlim_pkg::TIME_BITS'(60);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rlim_pkg::REG_LIMIT_GLOBAL:   lim_q[0] <= cfg_data[LB-1:0];
				rlim_pkg::REG_LIMIT_ADDRESS:  lim_q[1] <= cfg_data[LB-1:0];
				rlim_pkg::REG_LIMIT_IDENTITY: lim_q[2] <= cfg_data[LB-1:0];
				rlim_pkg::REG_LIMIT_PAIR:     lim_q[3] <= cfg_data[LB-1:0];
				rlim_pkg::REG_CAPACITY:       cap_q    <= cfg_data[CB-1:0];
				rlim_pkg::REG_WINDOW:         win_q    <= cfg_data[rlim_pkg::TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int s = 0; s < rlim_pkg::NUM_SCOPES; s++) begin
			if (lim_q[s] == '0)
				cfg_eff.limit[s] = LB'(1);
			else if (32'(lim_q[s]) > 32'(MAX_ATTEMPTS))
				cfg_eff.limit[s] = LB'(MAX_ATTEMPTS);
			else
				cfg_eff.limit[s] = lim_q[s];
		end
		if (cap_q < CB'(4))
			cfg_eff.capacity = CB'(4);
		else if (32'(cap_q) > 32'(BUCKETS))
			cfg_eff.capacity = CB'(BUCKETS);
		else
			cfg_eff.capacity = cap_q;
		cfg_eff.window = (win_q == '0) ? rlim_pkg::TIME_BITS'(1) : win_q;
	end

endmodule

>>> design/rlim_ctrl.sv
// Sequencer, bucket table and attempt log of the rate limiter.
// Walks the table for pruning, matching and eviction; depends on rlim_pkg.
module rlim_ctrl #(
	parameter int BUCKETS      = 64,
	parameter int MAX_ATTEMPTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rlim_pkg::cfg_t                    cfg_eff,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [rlim_pkg::KEY_BITS-1:0]     address_key,
	input  logic [rlim_pkg::KEY_BITS-1:0]     identity_key,
	input  logic [rlim_pkg::TIME_BITS-1:0]    now_seconds,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              allowed,
	output logic [rlim_pkg::TIME_BITS-1:0]    retry_after,
	output logic [2:0]                        limit_scope,
	output logic [6:0]                        bucket_count,
	output logic [31:0]                       rejection_total,
	output logic [31:0]                       eviction_total,
	output logic                              capacity_error
);
	localparam int BW = $clog2(BUCKETS);
	localparam int NW = $clog2(BUCKETS + 1);
	localparam int HW = (MAX_ATTEMPTS > 1) ? $clog2(MAX_ATTEMPTS) : 1;
	localparam int CW = $clog2(MAX_ATTEMPTS + 1);
	localparam int TD = BUCKETS * MAX_ATTEMPTS;
	localparam int TW = (TD > 1) ? $clog2(TD) : 1;
	localparam int T  = rlim_pkg::TIME_BITS;
	localparam int K  = rlim_pkg::KEY_BITS;
	localparam int NS = rlim_pkg::NUM_SCOPES;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_P_RD   = 4'd1;
	localparam logic [3:0] S_P_REC  = 4'd2;
	localparam logic [3:0] S_P_TIME = 4'd3;
	localparam logic [3:0] S_P_WB   = 4'd4;
	localparam logic [3:0] S_CHK    = 4'd5;
	localparam logic [3:0] S_RETRY  = 4'd6;
	localparam logic [3:0] S_EV_CHK = 4'd7;
	localparam logic [3:0] S_E_RD   = 4'd8;
	localparam logic [3:0] S_E_USE  = 4'd9;
	localparam logic [3:0] S_E_DONE = 4'd10;
	localparam logic [3:0] S_FREE   = 4'd11;
	localparam logic [3:0] S_REC    = 4'd12;
	localparam logic [3:0] S_OUT    = 4'd13;

	function automatic logic [HW-1:0] hinc(input logic [HW-1:0] h);
		logic [HW-1:0] r;
		r = (32'(h) == MAX_ATTEMPTS - 1) ? '0 : h + HW'(1);
		return r;
	endfunction

	function automatic logic [TW-1:0] taddr(input logic [BW-1:0] b, input logic [HW-1:0] h);
		logic [TW-1:0] r;
		r = TW'(TW'(b) * TW'(MAX_ATTEMPTS) + TW'(h));
		return r;
	endfunction

	// bucket table and attempt log
	logic [1:0]    m_scope [BUCKETS];
	logic [K-1:0]  m_addr  [BUCKETS];
	logic [K-1:0]  m_id    [BUCKETS];
	logic [T-1:0]  m_last  [BUCKETS];
	logic [HW-1:0] m_hd    [BUCKETS];
	logic [CW-1:0] m_cn    [BUCKETS];
	logic [T-1:0]  m_time  [TD];

	logic [1:0]    rd_scope;
	logic [K-1:0]  rd_addr, rd_id;
	logic [T-1:0]  rd_last;
	logic [HW-1:0] rd_hd;
	logic [CW-1:0] rd_cn;
	logic [T-1:0]  tm_rd;

	logic          rec_we;
	logic [BW-1:0] rec_wa;
	logic [1:0]    rec_w_scope;
	logic [K-1:0]  rec_w_addr, rec_w_id;
	logic [T-1:0]  rec_w_last;
	logic [HW-1:0] rec_w_hd;
	logic [CW-1:0] rec_w_cn;
	logic          tm_we;
	logic [TW-1:0] tm_wa, tm_ra;

	logic [3:0]    state_q;
	logic [BW-1:0] b_q;
	logic          func_q;
	logic [K-1:0]  a_q, id_q;
	logic [T-1:0]  now_q;
	logic [HW-1:0] hd_q;
	logic [CW-1:0] cn_q;
	logic [T-1:0]  t_q;
	logic [NS-1:0]            found_q;
	logic [NS-1:0][BW-1:0]    slot_q;
	logic [NS-1:0][CW-1:0]    scnt_q;
	logic [NS-1:0][HW-1:0]    shd_q;
	logic [NS-1:0][T-1:0]     st0_q;
	logic [BUCKETS-1:0]       valid_q;
	logic [NW-1:0]            held_q;
	logic [31:0]              rej_q, evc_q;
	logic                     best_ok_q;
	logic [BW-1:0]            best_q;
	logic [T-1:0]             best_t_q;
	logic [1:0]               s_q, hit_q;
	logic [T+1:0]             sum_q;
	logic                     p_allowed_q, p_cerr_q;
	logic [T-1:0]             p_retry_q;
	logic [2:0]               p_scope_q;
	logic                     out_valid_q, out_allowed_q, out_cerr_q;
	logic [T-1:0]             out_retry_q;
	logic [2:0]               out_scope_q;
	logic [6:0]               out_count_q;
	logic [31:0]              out_rej_q, out_evc_q;

	logic          last_b;
	logic          expired;
	logic [NS-1:0] match;
	logic [NS-1:0] full;
	logic          any_full;
	logic [1:0]    first_full;
	logic [2:0]    missing;
	logic          cand;
	logic [T+1:0]  diff;
	logic [HW-1:0] r_hd;
	logic [CW-1:0] r_cn;
	logic [CW:0]   r_pos;

	assign last_b  = (b_q == BW'(BUCKETS - 1));
	assign expired = (tm_rd <= now_q) && ((now_q - tm_rd) >= cfg_eff.window);
	assign diff    = sum_q - {2'b00, now_q};

	always_comb begin
		for (int s = 0; s < NS; s++) begin
			match[s] = (rd_scope == 2'(s))
				&& (!(s == 1 || s == 3) || rd_addr == a_q)
				&& (!(s == 2 || s == 3) || rd_id == id_q);
			full[s] = found_q[s] && (10'(scnt_q[s]) >= 10'(cfg_eff.limit[s]));
		end
		any_full   = |full;
		first_full = full[0] ? 2'd0 : full[1] ? 2'd1 : full[2] ? 2'd2 : 2'd3;
		missing    = 3'(NS) - 3'($countones(found_q));
		cand = valid_q[b_q] && (rd_scope != rlim_pkg::BSCOPE_GLOBAL)
			&& !(found_q[1] && slot_q[1] == b_q)
			&& !(found_q[2] && slot_q[2] == b_q)
			&& !(found_q[3] && slot_q[3] == b_q);
		r_hd = shd_q[s_q];
		r_cn = scnt_q[s_q];
		if (32'(r_cn) >= MAX_ATTEMPTS) begin
			r_hd = hinc(r_hd);
			r_cn = CW'(MAX_ATTEMPTS - 1);
		end
		r_pos = (CW + 1)'(r_hd) + (CW + 1)'(r_cn);
		if (32'(r_pos) >= MAX_ATTEMPTS)
			r_pos = r_pos - (CW + 1)'(MAX_ATTEMPTS);
	end

	always_comb begin
		tm_ra       = taddr(b_q, hd_q);
		rec_we      = 1'b0;
		rec_wa      = b_q;
		rec_w_scope = rd_scope;
		rec_w_addr  = rd_addr;
		rec_w_id    = rd_id;
		rec_w_last  = rd_last;
		rec_w_hd    = hd_q;
		rec_w_cn    = cn_q;
		tm_we       = 1'b0;
		tm_wa       = taddr(slot_q[s_q], r_pos[HW-1:0]);
		unique case (state_q)
			S_P_REC:  tm_ra = taddr(b_q, rd_hd);
			S_P_TIME: tm_ra = taddr(b_q, hinc(hd_q));
			S_P_WB:   rec_we = 1'b1;
			S_REC: begin
				rec_we      = 1'b1;
				rec_wa      = slot_q[s_q];
				rec_w_scope = s_q;
				rec_w_addr  = (s_q == rlim_pkg::BSCOPE_ADDRESS || s_q == rlim_pkg::BSCOPE_PAIR)
					? a_q : '0;
				rec_w_id    = (s_q == rlim_pkg::BSCOPE_IDENTITY || s_q == rlim_pkg::BSCOPE_PAIR)
					? id_q : '0;
				rec_w_last  = now_q;
				rec_w_hd    = r_hd;
				rec_w_cn    = r_cn + CW'(1);
				tm_we       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			m_scope[rec_wa] <= rec_w_scope;
			m_addr[rec_wa]  <= rec_w_addr;
			m_id[rec_wa]    <= rec_w_id;
			m_last[rec_wa]  <= rec_w_last;
			m_hd[rec_wa]    <= rec_w_hd;
			m_cn[rec_wa]    <= rec_w_cn;
		end
		rd_scope <= m_scope[b_q];
		rd_addr  <= m_addr[b_q];
		rd_id    <= m_id[b_q];
		rd_last  <= m_last[b_q];
		rd_hd    <= m_hd[b_q];
		rd_cn    <= m_cn[b_q];
	end

	always_ff @(posedge clk) begin
		if (tm_we)
			m_time[tm_wa] <= now_q;
		tm_rd <= m_time[tm_ra];
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			b_q         <= '0;
			found_q     <= '0;
			valid_q     <= '0;
			held_q      <= '0;
			rej_q       <= '0;
			evc_q       <= '0;
			best_ok_q   <= 1'b0;
			s_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						a_q     <= address_key;
						id_q    <= identity_key;
						now_q   <= now_seconds;
						b_q     <= '0;
						found_q <= '0;
						state_q <= S_P_RD;
					end
				end
				S_P_RD: begin
					if (valid_q[b_q])
						state_q <= S_P_REC;
					else if (last_b)
						state_q <= func_q ? S_OUT : S_CHK;
					else
						b_q <= b_q + BW'(1);
					p_allowed_q <= 1'b1;
					p_retry_q   <= '0;
					p_scope_q   <= rlim_pkg::LSCOPE_NONE;
					p_cerr_q    <= 1'b0;
				end
				S_P_REC: begin
					hd_q    <= rd_hd;
					cn_q    <= rd_cn;
					state_q <= (rd_cn == '0) ? S_P_WB : S_P_TIME;
				end
				S_P_TIME: begin
					if (expired) begin
						hd_q <= hinc(hd_q);
						cn_q <= cn_q - CW'(1);
						if (cn_q == CW'(1))
							state_q <= S_P_WB;
					end else begin
						t_q     <= tm_rd;
						state_q <= S_P_WB;
					end
				end
				S_P_WB: begin
					if (cn_q == '0) begin
						valid_q[b_q] <= 1'b0;
						held_q       <= held_q - NW'(1);
					end else begin
						for (int s = 0; s < NS; s++) begin
							if (!found_q[s] && match[s]) begin
								found_q[s] <= 1'b1;
								slot_q[s]  <= b_q;
								scnt_q[s]  <= cn_q;
								shd_q[s]   <= hd_q;
								st0_q[s]   <= t_q;
							end
						end
					end
					if (last_b)
						state_q <= func_q ? S_OUT : S_CHK;
					else begin
						b_q     <= b_q + BW'(1);
						state_q <= S_P_RD;
					end
				end
				S_CHK: begin
					if (any_full) begin
						if (rej_q != '1)
							rej_q <= rej_q + 32'd1;
						hit_q   <= first_full;
						sum_q   <= {2'b00, st0_q[first_full]} + {2'b00, cfg_eff.window}
							+ (T + 2)'(1);
						state_q <= S_RETRY;
					end else
						state_q <= S_EV_CHK;
				end
				S_RETRY: begin
					p_allowed_q <= 1'b0;
					p_scope_q   <= 3'(hit_q) + 3'd1;
					if (diff[T+1:T] != 2'b00)
						p_retry_q <= '1;
					else if (diff[T-1:0] == '0)
						p_retry_q <= T'(1);
					else
						p_retry_q <= diff[T-1:0];
					state_q <= S_OUT;
				end
				S_EV_CHK: begin
					b_q       <= '0;
					best_ok_q <= 1'b0;
					s_q       <= '0;
					if (12'(held_q) + 12'(missing) > 12'(cfg_eff.capacity))
						state_q <= S_E_RD;
					else
						state_q <= S_FREE;
				end
				S_E_RD: state_q <= S_E_USE;
				S_E_USE: begin
					if (cand && (!best_ok_q || rd_last < best_t_q)) begin
						best_ok_q <= 1'b1;
						best_q    <= b_q;
						best_t_q  <= rd_last;
					end
					if (last_b)
						state_q <= S_E_DONE;
					else begin
						b_q     <= b_q + BW'(1);
						state_q <= S_E_RD;
					end
				end
				S_E_DONE: begin
					if (!best_ok_q) begin
						p_allowed_q <= 1'b0;
						p_cerr_q    <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						valid_q[best_q] <= 1'b0;
						held_q          <= held_q - NW'(1);
						if (evc_q != '1)
							evc_q <= evc_q + 32'd1;
						state_q <= S_EV_CHK;
					end
				end
				S_FREE: begin
					if (found_q[s_q] || !valid_q[b_q]) begin
						if (!found_q[s_q]) begin
							slot_q[s_q]  <= b_q;
							scnt_q[s_q]  <= '0;
							shd_q[s_q]   <= '0;
							valid_q[b_q] <= 1'b1;
							held_q       <= held_q + NW'(1);
						end
						s_q <= s_q + 2'd1;
						if (s_q == 2'(NS - 1))
							state_q <= S_REC;
					end else if (last_b) begin
						p_allowed_q <= 1'b0;
						p_cerr_q    <= 1'b1;
						state_q     <= S_OUT;
					end else
						b_q <= b_q + BW'(1);
				end
				S_REC: begin
					s_q <= s_q + 2'd1;
					if (s_q == 2'(NS - 1))
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						out_allowed_q <= p_allowed_q;
						out_retry_q   <= p_retry_q;
						out_scope_q   <= p_scope_q;
						out_cerr_q    <= p_cerr_q;
						out_count_q   <= 7'(held_q);
						out_rej_q     <= rej_q;
						out_evc_q     <= evc_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign allowed         = out_allowed_q;
	assign retry_after     = out_retry_q;
	assign limit_scope     = out_scope_q;
	assign bucket_count    = out_count_q;
	assign rejection_total = out_rej_q;
	assign eviction_total  = out_evc_q;
	assign capacity_error  = out_cerr_q;

	a_held_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == NW'($countones(valid_q)))
		else $error("held count differs from valid bits");

	a_cerr_not_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_cerr_q |-> !out_allowed_q && out_scope_q == rlim_pkg::LSCOPE_NONE)
		else $error("capacity error with allowed result");

	a_allowed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_allowed_q |-> out_retry_q == '0
			&& out_scope_q == rlim_pkg::LSCOPE_NONE)
		else $error("allowed result carries retry or scope");

	a_reject_retry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_allowed_q && !out_cerr_q |-> out_retry_q != '0
			&& out_scope_q != rlim_pkg::LSCOPE_NONE)
		else $error("rejection without retry time or scope");

endmodule

>>> design/multi_scope_login_rate_limiter_top.sv
// Top level of the multi-scope login rate limiter.
// Instantiates rlim_cfg and rlim_ctrl; depends on rlim_pkg.
//
// Input channel (in_valid/in_ready) takes one attempt transaction: func,
// address_key, identity_key, now_seconds. Output channel (out_valid/out_ready)
// returns one result transaction per input. Configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six registers and is
// always ready; write it only while no transaction is in flight.
// An item walks the bucket table through one read port: pruning visits every
// bucket and, for each held bucket, the logged times it examines; a rejection
// then computes the retry time, each eviction scans every bucket for the oldest
// candidate, slot allocation searches for free buckets and recording writes
// every scope, and the result is then loaded into the output register.
// One item is in work at a time; in_ready rises after the result is loaded
// into the output register, so a new item may start while the previous
// result still waits for out_ready. A stalled receiver holds the sequencer
// in its final step until the register frees.
// Reset clears all buckets, the counters and the output valid, and loads the
// register defaults 16, 8, 8, 4, 64 and 60.
module multi_scope_login_rate_limiter_top #(
	parameter int BUCKETS      = 64,
	parameter int MAX_ATTEMPTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rlim_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [rlim_pkg::DATA_BITS-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [rlim_pkg::KEY_BITS-1:0]     address_key,
	input  logic [rlim_pkg::KEY_BITS-1:0]     identity_key,
	input  logic [rlim_pkg::TIME_BITS-1:0]    now_seconds,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              allowed,
	output logic [rlim_pkg::TIME_BITS-1:0]    retry_after,
	output logic [2:0]                        limit_scope,
	output logic [6:0]                        bucket_count,
	output logic [31:0]                       rejection_total,
	output logic [31:0]                       eviction_total,
	output logic                              capacity_error
);
	rlim_pkg::cfg_t cfg_eff;

	rlim_cfg #(
		.BUCKETS      (BUCKETS),
		.MAX_ATTEMPTS (MAX_ATTEMPTS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_eff   (cfg_eff)
	);

	rlim_ctrl #(
		.BUCKETS      (BUCKETS),
		.MAX_ATTEMPTS (MAX_ATTEMPTS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_eff         (cfg_eff),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.address_key     (address_key),
		.identity_key    (identity_key),
		.now_seconds     (now_seconds),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.allowed         (allowed),
		.retry_after     (retry_after),
		.limit_scope     (limit_scope),
		.bucket_count    (bucket_count),
		.rejection_total (rejection_total),
		.eviction_total  (eviction_total),
		.capacity_error  (capacity_error)
	);

endmodule
